// ----- hdl/hap_pkg.sv -----
// Shared types and constants for the hold-to-approve prompt block.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
`default_nettype none

package hap_pkg;

    localparam int TIME_BITS     = 48;
    localparam int TIMEOUT_BITS  = 32;
    localparam int THR_BITS      = 24;
    localparam int PERMILLE_BITS = 10;
    localparam int SPAN_BITS     = TIMEOUT_BITS + PERMILLE_BITS;
    localparam int SUM_BITS      = ((TIME_BITS > SPAN_BITS) ? TIME_BITS : SPAN_BITS) + 1;
    localparam int PROD_BITS     = THR_BITS + PERMILLE_BITS;
    localparam int DIV_STEPS     = PERMILLE_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int STATUS_BITS   = 3;

    localparam logic [PERMILLE_BITS-1:0] PERMILLE = PERMILLE_BITS'(1000);

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST  = TIMEOUT_BITS'(30000);
    localparam logic [THR_BITS-1:0]     HOLD_RST     = THR_BITS'(2000000);
    localparam logic [THR_BITS-1:0]     DEBOUNCE_RST = THR_BITS'(50000);
    localparam logic [THR_BITS-1:0]     BOUNCE_RST   = THR_BITS'(50000);

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_IDLE    = 3'd0,
        STAT_PENDING = 3'd1,
        STAT_GRANTED = 3'd2,
        STAT_DENIED  = 3'd3,
        STAT_EXPIRED = 3'd4
    } status_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_POLL  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TIMEOUT_MS      = 2'd0,
        CFG_HOLD_TIME       = 2'd1,
        CFG_CANCEL_DEBOUNCE = 2'd2,
        CFG_RELEASE_BOUNCE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SINCE_CANCEL,
        SINCE_HOLD,
        SINCE_RELEASE,
        SINCE_DEADLINE
    } since_sel_t;

    typedef enum logic [1:0] {
        THR_DEBOUNCE,
        THR_HOLD,
        THR_BOUNCE
    } thr_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAN,
        S_ARM,
        S_CANCEL,
        S_CANCEL_CHK,
        S_APPROVE,
        S_GRANT_CHK,
        S_BOUNCE_CHK,
        S_HOLD_CHK,
        S_DL_CHK,
        S_PROG,
        S_MUL,
        S_DIV,
        S_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       span;
        logic       arm;
        logic       cancel_upd;
        logic       approve_upd;
        logic       release_clr;
        logic       deny;
        logic       grant;
        logic       expire;
        logic       fin_save;
        logic       prog_load;
        logic       prog_full;
        logic       held_save;
        logic       mul;
        logic       div_step;
        logic       out_load;
        since_sel_t since_sel;
        thr_sel_t   thr_sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_poll;
        logic pending;
        logic granted;
        logic a_eff;
        logic c_eff;
        logic holding;
        logic rseen;
        logic cdown;
        logic el_ge;
        logic el_not_before;
        logic el_zero;
        logic fin_ok;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/hap_if.sv -----
// Handshake channel interfaces of the hold-to-approve prompt: request, result, config.
// Depends on hap_pkg for field widths.
`default_nettype none

interface hap_item_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic                          approve_level;
    logic                          cancel_level;
    logic [hap_pkg::TIME_BITS-1:0] now_time;

    modport source (output valid, operation, approve_level, cancel_level, now_time,
                    input ready);
    modport sink   (input valid, operation, approve_level, cancel_level, now_time,
                    output ready);
endinterface

interface hap_result_if;
    logic                              valid;
    logic                              ready;
    logic [hap_pkg::STATUS_BITS-1:0]   status;
    logic [hap_pkg::PERMILLE_BITS-1:0] progress_permille;

    modport source (output valid, status, progress_permille, input ready);
    modport sink   (input valid, status, progress_permille, output ready);
endinterface

interface hap_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hap_pkg::CFG_IDX_BITS-1:0]  index;
    logic [hap_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/hap_ctrl.sv -----
// Sequencing state machine of the hold-to-approve prompt.
// Depends on hap_pkg; drives hap_datapath through cmd_t and reads sts_t.
`default_nettype none

module hap_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hap_pkg::sts_t sts,
    output hap_pkg::cmd_t      cmd
);

    hap_pkg::ctrl_state_t state_reg;
    hap_pkg::ctrl_state_t state_next;

    logic finishing;
    logic imm_zero;
    logic imm_full;

    assign finishing = sts.holding && sts.fin_ok && !sts.el_ge;
    assign imm_full  = sts.granted
                       || (sts.pending && sts.holding && !sts.el_zero && sts.el_ge);
    assign imm_zero  = !sts.granted && (!sts.pending || !sts.holding || sts.el_zero);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hap_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hap_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = hap_pkg::S_SPAN;
            end
            hap_pkg::S_SPAN:
            begin
                if (!sts.op_poll)
                    state_next = hap_pkg::S_ARM;
                else if (sts.pending)
                    state_next = hap_pkg::S_CANCEL;
                else
                    state_next = hap_pkg::S_PROG;
            end
            hap_pkg::S_ARM:
                state_next = hap_pkg::S_PROG;
            hap_pkg::S_CANCEL:
                state_next = sts.c_eff ? hap_pkg::S_CANCEL_CHK : hap_pkg::S_APPROVE;
            hap_pkg::S_CANCEL_CHK:
                state_next = sts.el_ge ? hap_pkg::S_PROG : hap_pkg::S_APPROVE;
            hap_pkg::S_APPROVE:
            begin
                if (sts.a_eff)
                    state_next = hap_pkg::S_GRANT_CHK;
                else if (sts.holding && sts.rseen)
                    state_next = hap_pkg::S_BOUNCE_CHK;
                else
                    state_next = hap_pkg::S_HOLD_CHK;
            end
            hap_pkg::S_GRANT_CHK:
                state_next = (!sts.cdown && sts.el_ge) ? hap_pkg::S_PROG : hap_pkg::S_HOLD_CHK;
            hap_pkg::S_BOUNCE_CHK:
                state_next = hap_pkg::S_HOLD_CHK;
            hap_pkg::S_HOLD_CHK:
                state_next = hap_pkg::S_DL_CHK;
            hap_pkg::S_DL_CHK:
                state_next = hap_pkg::S_PROG;
            hap_pkg::S_PROG:
                state_next = (imm_zero || imm_full) ? hap_pkg::S_OUT : hap_pkg::S_MUL;
            hap_pkg::S_MUL:
                state_next = hap_pkg::S_DIV;
            hap_pkg::S_DIV:
            begin
                if (sts.div_last)
                    state_next = hap_pkg::S_OUT;
            end
            hap_pkg::S_OUT:
            begin
                if (sts.out_free)
                    state_next = hap_pkg::S_IDLE;
            end
            default:
                state_next = hap_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.since_sel = hap_pkg::SINCE_HOLD;
        cmd.thr_sel   = hap_pkg::THR_HOLD;
        in_ready      = 1'b0;
        unique case (state_reg)
            hap_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            hap_pkg::S_SPAN:
                cmd.span = 1'b1;
            hap_pkg::S_ARM:
                cmd.arm = 1'b1;
            hap_pkg::S_CANCEL:
                cmd.cancel_upd = 1'b1;
            hap_pkg::S_CANCEL_CHK:
            begin
                cmd.since_sel = hap_pkg::SINCE_CANCEL;
                cmd.thr_sel   = hap_pkg::THR_DEBOUNCE;
                cmd.deny      = sts.el_ge;
            end
            hap_pkg::S_APPROVE:
                cmd.approve_upd = 1'b1;
            hap_pkg::S_GRANT_CHK:
                cmd.grant = !sts.cdown && sts.el_ge;
            hap_pkg::S_BOUNCE_CHK:
            begin
                cmd.since_sel   = hap_pkg::SINCE_RELEASE;
                cmd.thr_sel     = hap_pkg::THR_BOUNCE;
                cmd.release_clr = sts.el_ge;
            end
            hap_pkg::S_HOLD_CHK:
                cmd.fin_save = 1'b1;
            hap_pkg::S_DL_CHK:
            begin
                cmd.since_sel = hap_pkg::SINCE_DEADLINE;
                cmd.expire    = sts.el_not_before && !finishing;
            end
            hap_pkg::S_PROG:
            begin
                cmd.prog_load = imm_zero || imm_full;
                cmd.prog_full = imm_full;
                cmd.held_save = !(imm_zero || imm_full);
            end
            hap_pkg::S_MUL:
                cmd.mul = 1'b1;
            hap_pkg::S_DIV:
                cmd.div_step = 1'b1;
            hap_pkg::S_OUT:
                cmd.out_load = sts.out_free;
            default:
                cmd.since_sel = hap_pkg::SINCE_HOLD;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/hap_datapath.sv -----
// Datapath of the hold-to-approve prompt: config and prompt registers, elapsed-time
// comparator, deadline adder, radix-2 permille divider, result register. Depends on hap_pkg.
`default_nettype none

module hap_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hap_pkg::cmd_t                       cmd,
    output hap_pkg::sts_t                            sts,
    input  wire logic                                item_operation,
    input  wire logic                                item_approve,
    input  wire logic                                item_cancel,
    input  wire logic [hap_pkg::TIME_BITS-1:0]       item_now,
    input  wire logic                                cfg_valid,
    input  wire logic [hap_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [hap_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [hap_pkg::STATUS_BITS-1:0]          out_status,
    output logic [hap_pkg::PERMILLE_BITS-1:0]        out_progress
);

    localparam int TB = hap_pkg::TIME_BITS;

    // Configuration
    logic [hap_pkg::TIMEOUT_BITS-1:0] timeout_reg;
    logic [hap_pkg::THR_BITS-1:0]     hold_reg;
    logic [hap_pkg::THR_BITS-1:0]     debounce_reg;
    logic [hap_pkg::THR_BITS-1:0]     bounce_reg;

    // Captured request
    logic          op_reg;
    logic          appr_reg;
    logic          canc_reg;
    logic [TB-1:0] now_reg;

    // Prompt state
    hap_pkg::status_t status_reg;
    logic [TB-1:0]    deadline_reg;
    logic             a_stale_reg;
    logic             c_stale_reg;
    logic             holding_reg;
    logic [TB-1:0]    hstart_reg;
    logic             rseen_reg;
    logic [TB-1:0]    rstart_reg;
    logic             cdown_reg;
    logic [TB-1:0]    cstart_reg;

    // Working registers
    logic [hap_pkg::SPAN_BITS-1:0]     span_reg;
    logic                              fin_ok_reg;
    logic [hap_pkg::THR_BITS-1:0]      held_reg;
    logic [hap_pkg::PROD_BITS-1:0]     rem_reg;
    logic [hap_pkg::PROD_BITS-1:0]     dsh_reg;
    logic [hap_pkg::PERMILLE_BITS-1:0] q_reg;
    logic [hap_pkg::DIV_CNT_BITS-1:0]  div_cnt_reg;

    // Result register
    logic                              out_valid_reg;
    logic [hap_pkg::STATUS_BITS-1:0]   out_status_reg;
    logic [hap_pkg::PERMILLE_BITS-1:0] out_prog_reg;

    logic [TB-1:0]                 since;
    logic [hap_pkg::THR_BITS-1:0]  thr;
    logic [TB:0]                   diff;
    logic                          el_not_before;
    logic [TB-1:0]                 el;
    logic                          el_ge;
    logic [hap_pkg::SUM_BITS-1:0]  dl_sum;
    logic [TB-1:0]                 dl_next;
    logic                          a_eff;
    logic                          c_eff;
    logic                          div_fit;
    logic                          out_free;

    // Elapsed-time comparator, shared by every check
    always_comb
    begin
        unique case (cmd.since_sel)
            hap_pkg::SINCE_CANCEL:   since = cstart_reg;
            hap_pkg::SINCE_HOLD:     since = hstart_reg;
            hap_pkg::SINCE_RELEASE:  since = rstart_reg;
            hap_pkg::SINCE_DEADLINE: since = deadline_reg;
            default:                 since = hstart_reg;
        endcase
        unique case (cmd.thr_sel)
            hap_pkg::THR_DEBOUNCE: thr = debounce_reg;
            hap_pkg::THR_HOLD:     thr = hold_reg;
            hap_pkg::THR_BOUNCE:   thr = bounce_reg;
            default:               thr = hold_reg;
        endcase
    end

    assign diff          = {1'b0, now_reg} - {1'b0, since};
    assign el_not_before = ~diff[TB];
    assign el            = el_not_before ? diff[TB-1:0] : '0;
    assign el_ge         = el >= TB'(thr);

    // Deadline: now plus span, clamped at the top of the time range
    assign dl_sum  = hap_pkg::SUM_BITS'(now_reg) + hap_pkg::SUM_BITS'(span_reg);
    assign dl_next = (|dl_sum[hap_pkg::SUM_BITS-1:TB]) ? '1 : dl_sum[TB-1:0];

    assign a_eff    = appr_reg & ~a_stale_reg;
    assign c_eff    = canc_reg & ~c_stale_reg;
    assign div_fit  = rem_reg >= dsh_reg;
    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        sts               = '0;
        sts.op_poll       = (op_reg == hap_pkg::OP_POLL);
        sts.pending       = (status_reg == hap_pkg::STAT_PENDING);
        sts.granted       = (status_reg == hap_pkg::STAT_GRANTED);
        sts.a_eff         = a_eff;
        sts.c_eff         = c_eff;
        sts.holding       = holding_reg;
        sts.rseen         = rseen_reg;
        sts.cdown         = cdown_reg;
        sts.el_ge         = el_ge;
        sts.el_not_before = el_not_before;
        sts.el_zero       = (el == '0);
        sts.fin_ok        = fin_ok_reg;
        sts.div_last      = (div_cnt_reg == '0);
        sts.out_free      = out_free;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= hap_pkg::TIMEOUT_RST;
            hold_reg     <= hap_pkg::HOLD_RST;
            debounce_reg <= hap_pkg::DEBOUNCE_RST;
            bounce_reg   <= hap_pkg::BOUNCE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (hap_pkg::cfg_idx_t'(cfg_index))
                hap_pkg::CFG_TIMEOUT_MS:      timeout_reg  <= cfg_data;
                hap_pkg::CFG_HOLD_TIME:       hold_reg     <= cfg_data[hap_pkg::THR_BITS-1:0];
                hap_pkg::CFG_CANCEL_DEBOUNCE: debounce_reg <= cfg_data[hap_pkg::THR_BITS-1:0];
                hap_pkg::CFG_RELEASE_BOUNCE:  bounce_reg   <= cfg_data[hap_pkg::THR_BITS-1:0];
                default:                      timeout_reg  <= timeout_reg;
            endcase
        end
    end

    // Prompt state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg   <= hap_pkg::STAT_IDLE;
            deadline_reg <= '0;
            a_stale_reg  <= 1'b1;
            c_stale_reg  <= 1'b1;
            holding_reg  <= 1'b0;
            hstart_reg   <= '0;
            rseen_reg    <= 1'b0;
            rstart_reg   <= '0;
            cdown_reg    <= 1'b0;
            cstart_reg   <= '0;
        end
        else
        begin
            if (cmd.arm)
            begin
                status_reg   <= hap_pkg::STAT_PENDING;
                deadline_reg <= dl_next;
                a_stale_reg  <= 1'b1;
                c_stale_reg  <= 1'b1;
                holding_reg  <= 1'b0;
                hstart_reg   <= '0;
                rseen_reg    <= 1'b0;
                rstart_reg   <= '0;
                cdown_reg    <= 1'b0;
                cstart_reg   <= '0;
            end
            if (cmd.cancel_upd)
            begin
                a_stale_reg <= a_stale_reg & appr_reg;
                c_stale_reg <= c_stale_reg & canc_reg;
                if (c_eff)
                begin
                    if (!cdown_reg)
                    begin
                        cdown_reg  <= 1'b1;
                        cstart_reg <= now_reg;
                    end
                end
                else
                begin
                    cdown_reg <= 1'b0;
                end
            end
            if (cmd.approve_upd)
            begin
                if (a_eff)
                begin
                    if (!holding_reg)
                    begin
                        holding_reg <= 1'b1;
                        hstart_reg  <= now_reg;
                    end
                    rseen_reg <= 1'b0;
                end
                else if (holding_reg && !rseen_reg)
                begin
                    rseen_reg  <= 1'b1;
                    rstart_reg <= now_reg;
                end
            end
            if (cmd.release_clr)
            begin
                holding_reg <= 1'b0;
                rseen_reg   <= 1'b0;
            end
            if (cmd.deny)
                status_reg <= hap_pkg::STAT_DENIED;
            if (cmd.grant)
                status_reg <= hap_pkg::STAT_GRANTED;
            if (cmd.expire)
                status_reg <= hap_pkg::STAT_EXPIRED;
        end
    end

    // Request capture and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= item_operation;
            appr_reg <= item_approve;
            canc_reg <= item_cancel;
            now_reg  <= item_now;
        end
        if (cmd.span)
            span_reg <= hap_pkg::SPAN_BITS'(timeout_reg) * hap_pkg::SPAN_BITS'(hap_pkg::PERMILLE);
        if (cmd.fin_save)
            fin_ok_reg <= ~el_ge;
        if (cmd.held_save)
            held_reg <= el[hap_pkg::THR_BITS-1:0];
        if (cmd.prog_load)
            q_reg <= cmd.prog_full ? hap_pkg::PERMILLE : '0;
        if (cmd.mul)
        begin
            rem_reg     <= hap_pkg::PROD_BITS'(held_reg)
                           * hap_pkg::PROD_BITS'(hap_pkg::PERMILLE);
            dsh_reg     <= hap_pkg::PROD_BITS'(hold_reg) << (hap_pkg::DIV_STEPS - 1);
            q_reg       <= '0;
            div_cnt_reg <= hap_pkg::DIV_CNT_BITS'(hap_pkg::DIV_STEPS - 1);
        end
        if (cmd.div_step)
        begin
            if (div_fit)
                rem_reg <= rem_reg - dsh_reg;
            q_reg       <= {q_reg[hap_pkg::PERMILLE_BITS-2:0], div_fit};
            dsh_reg     <= dsh_reg >> 1;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_prog_reg   <= q_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_progress = out_prog_reg;

endmodule

`default_nettype wire

// ----- hdl/hold_to_approve_prompt.sv -----
// Top level of the hold-to-approve prompt: controller plus datapath behind three channels.
// Depends on hap_pkg, hap_if (channel interfaces), hap_ctrl and hap_datapath.
`default_nettype none

// Two-button confirmation prompt. A request with operation 0 arms a prompt whose
// deadline is now_time plus 1000 times the timeout register (milliseconds), clamped
// at the largest time value; operation 1 polls the approve and cancel levels at
// now_time. Each request yields exactly one result: the prompt status (idle, pending,
// granted, denied, expired) and the approve hold progress in permille. One request
// is worked on at a time. The controller walks a poll through one shared elapsed-time
// comparator (one check per cycle), and a 10-step radix-2 divider forms the permille
// value when a hold is partly done. The result sits in an output register, so a new
// request is taken while the previous result waits; if that result is still waiting
// when the next one is done, the controller holds it and takes no new request.
// Configuration writes are always ready and take effect at once; write them only
// while no request is in flight. now_time must not decrease between requests;
// if it does, elapsed times read as zero.

module hold_to_approve_prompt (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hap_item_if.sink     item,
    hap_result_if.source result,
    hap_cfg_if.sink      cfg
);

    hap_pkg::cmd_t cmd;
    hap_pkg::sts_t sts;
    logic          in_ready;

    // Config is register writes only; never stall the writer.
    assign cfg.ready  = 1'b1;
    assign item.ready = in_ready;

    hap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hap_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .item_operation (item.operation),
        .item_approve   (item.approve_level),
        .item_cancel    (item.cancel_level),
        .item_now       (item.now_time),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_status     (result.status),
        .out_progress   (result.progress_permille)
    );

endmodule

`default_nettype wire

// ----- hdl/hap_checker.sv -----
// Port-level assertions for hold_to_approve_prompt, attached by bind.
// Depends on hap_pkg and the top level's channel ports.
`default_nettype none

module hap_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                item_valid,
    input wire logic                                item_ready,
    input wire logic                                result_valid,
    input wire logic                                result_ready,
    input wire logic [hap_pkg::STATUS_BITS-1:0]     status,
    input wire logic [hap_pkg::PERMILLE_BITS-1:0]   progress
);

    // Hold a stalled result.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status) && $stable(progress))
        else $error("result changed or dropped while stalled");

    // A granted prompt reports a full hold.
    a_grant_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == hap_pkg::STAT_GRANTED |-> progress == hap_pkg::PERMILLE)
        else $error("granted result without full progress");

    // Idle, denied and expired prompts report no progress; pending never exceeds full.
    a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != hap_pkg::STAT_PENDING && status != hap_pkg::STAT_GRANTED
        |-> progress == '0)
        else $error("progress reported outside a hold");

    a_prog_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> progress <= hap_pkg::PERMILLE)
        else $error("progress above full scale");

    // Ready is low in the cycle after a request is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("request taken on back-to-back cycles");

endmodule

bind hold_to_approve_prompt hap_checker u_hap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (result.status),
    .progress     (result.progress_permille)
);

`default_nettype wire

// ----- test/hap_prompt_check.sv -----
// Scoreboard for the hold-to-approve prompt: mirrors the prompt state from the observed
// requests and register writes, and compares every result with the predicted one.
// Depends on hap_pkg and the channel interfaces of hap_if.

module hap_prompt_check
    import hap_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    hap_item_if       item,
    hap_result_if     result,
    hap_cfg_if        cfg,
    output int        fail_count,
    output int        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [TIME_BITS-1:0] usec_t;

    localparam usec_t TIME_MAX = '1;

    typedef struct packed {
        status_t                  status;
        logic [PERMILLE_BITS-1:0] permille;
    } outcome_t;

    outcome_t prompt_outcomes[$];

    logic [TIMEOUT_BITS-1:0] lifetime_ms;
    logic [THR_BITS-1:0]     hold_us;
    logic [THR_BITS-1:0]     debounce_us;
    logic [THR_BITS-1:0]     bounce_us;

    status_t st;
    usec_t   deadline;
    usec_t   hold_t0;
    usec_t   rel_t0;
    usec_t   cancel_t0;
    bit      appr_stale;
    bit      canc_stale;
    bit      holding;
    bit      rel_seen;
    bit      canc_pressed;
    int      mismatches;

    // Elapsed time, clamped at zero when the clock went backwards.
    function automatic usec_t since(usec_t now, usec_t t0);
        return (now >= t0) ? now - t0 : '0;
    endfunction

    function automatic logic [PERMILLE_BITS-1:0] hold_permille(usec_t now);
        usec_t       held;
        logic [63:0] prod;
        if (st == STAT_GRANTED)
            return PERMILLE;
        if (st != STAT_PENDING || !holding)
            return '0;
        held = since(now, hold_t0);
        if (held == '0)
            return '0;
        if (held >= usec_t'(hold_us))
            return PERMILLE;
        prod = 64'(held) * 64'd1000;
        return PERMILLE_BITS'(prod / 64'(hold_us));
    endfunction

    function automatic void arm_prompt(usec_t now);
        logic [63:0] span;
        span = 64'(lifetime_ms) * 64'd1000;
        if (span > 64'(TIME_MAX - now))
            deadline = TIME_MAX;
        else
            deadline = now + usec_t'(span);
        st           = STAT_PENDING;
        appr_stale   = 1'b1;
        canc_stale   = 1'b1;
        holding      = 1'b0;
        hold_t0      = '0;
        rel_seen     = 1'b0;
        rel_t0       = '0;
        canc_pressed = 1'b0;
        cancel_t0    = '0;
    endfunction

    function automatic void poll_buttons(bit a_lvl, bit c_lvl, usec_t now);
        bit a;
        bit c;
        bit finishing;
        if (st != STAT_PENDING)
            return;
        if (!a_lvl)
            appr_stale = 1'b0;
        if (!c_lvl)
            canc_stale = 1'b0;
        a = a_lvl && !appr_stale;
        c = c_lvl && !canc_stale;

        if (c) begin
            if (!canc_pressed) begin
                canc_pressed = 1'b1;
                cancel_t0    = now;
            end
            if (since(now, cancel_t0) >= usec_t'(debounce_us)) begin
                st = STAT_DENIED;
                return;
            end
        end
        else begin
            canc_pressed = 1'b0;
        end

        if (a) begin
            if (!holding) begin
                holding = 1'b1;
                hold_t0 = now;
            end
            rel_seen = 1'b0;
            if (!canc_pressed && since(now, hold_t0) >= usec_t'(hold_us)) begin
                st = STAT_GRANTED;
                return;
            end
        end
        else if (holding) begin
            if (!rel_seen) begin
                rel_seen = 1'b1;
                rel_t0   = now;
            end
            else if (since(now, rel_t0) >= usec_t'(bounce_us)) begin
                holding  = 1'b0;
                rel_seen = 1'b0;
            end
        end

        // Past the deadline only a hold still inside its grace window survives.
        if (now >= deadline) begin
            finishing = holding && since(now, hold_t0) < usec_t'(hold_us) &&
                        (now - deadline) < usec_t'(hold_us);
            if (!finishing)
                st = STAT_EXPIRED;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t want;
        if (!rst_n) begin
            lifetime_ms = TIMEOUT_RST;
            hold_us     = HOLD_RST;
            debounce_us = DEBOUNCE_RST;
            bounce_us   = BOUNCE_RST;
            st           = STAT_IDLE;
            deadline     = '0;
            appr_stale   = 1'b1;
            canc_stale   = 1'b1;
            holding      = 1'b0;
            hold_t0      = '0;
            rel_seen     = 1'b0;
            rel_t0       = '0;
            canc_pressed = 1'b0;
            cancel_t0    = '0;
            prompt_outcomes.delete();
            mismatches = 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg_idx_t'(cfg.index))
                    CFG_TIMEOUT_MS:      lifetime_ms = cfg.data[TIMEOUT_BITS-1:0];
                    CFG_HOLD_TIME:       hold_us     = cfg.data[THR_BITS-1:0];
                    CFG_CANCEL_DEBOUNCE: debounce_us = cfg.data[THR_BITS-1:0];
                    CFG_RELEASE_BOUNCE:  bounce_us   = cfg.data[THR_BITS-1:0];
                endcase
            end

            // Compare before queuing: a request taken at this edge has no result yet.
            if (result.valid && result.ready) begin
                if (prompt_outcomes.size() == 0) begin
                    mismatches++;
                    $error("result with no request outstanding: status %0d progress %0d",
                           result.status, result.progress_permille);
                end
                else begin
                    want = prompt_outcomes.pop_front();
                    if (result.status !== want.status) begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", want.status,
                               result.status);
                    end
                    if (result.progress_permille !== want.permille) begin
                        mismatches++;
                        $error("progress_permille: expected %0d, got %0d", want.permille,
                               result.progress_permille);
                    end
                end
            end

            if (item.valid && item.ready) begin
                if (op_t'(item.operation) == OP_START)
                    arm_prompt(item.now_time);
                else
                    poll_buttons(item.approve_level, item.cancel_level, item.now_time);
                want.status   = st;
                want.permille = hold_permille(item.now_time);
                prompt_outcomes.push_back(want);
            end
        end
        fail_count  <= mismatches;
        outstanding <= prompt_outcomes.size();
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the hold-to-approve prompt testbench: clock, reset, request and register stimulus,
// result back-pressure, watchdog and verdict. Depends on hap_pkg, hap_if, the block
// hold_to_approve_prompt and the scoreboard hap_prompt_check.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hap_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int WATCHDOG_LIMIT = 5000;   // cycles without any handshake
    localparam int STALL_CYCLES   = 300;    // long receiver hold-off
    localparam int TAIL_CYCLES    = 40;     // settle time after the last result
    localparam int PHASE_ITEMS    = 100;
    localparam int THR_MAX        = 16777215;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;

    always #(CLK_PERIOD / 2) clk = ~clk;

    hap_item_if   req_ch ();
    hap_result_if res_ch ();
    hap_cfg_if    cfg_ch ();

    int fail_count;
    int outstanding;

    hold_to_approve_prompt i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    hap_prompt_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (req_ch),
        .result      (res_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Idle rates in percent; the receiver rate is read by its own process.
    int send_idle = 25;
    int recv_idle = 72;

    // Hold-off handshake: stimulus bumps stall_asked, the receiver bumps stall_taken.
    int stall_asked = 0;
    int stall_taken = 0;
    int stall_left  = 0;

    int idle_cycles = 0;
    int sent        = 0;

    // Running microsecond clock of the stimulus and the settings now loaded.
    logic [TIME_BITS-1:0] now_us = '0;
    int hold_set;
    int deb_set;
    int bounce_set;

    // Result side: random back-pressure, plus a long hold-off each time the stimulus asks for one.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end
        else if (stall_left != 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (stall_taken != stall_asked) begin
            res_ch.ready <= 1'b0;
            stall_taken  <= stall_taken + 1;
            stall_left   <= STALL_CYCLES;
        end
        else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog: end the run when no channel has moved anything for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request after a random idle gap and hold it until it is taken.
    // Return at the accepting edge so that back-to-back requests keep valid high.
    task automatic send_request(op_t op, bit a_lvl, bit c_lvl, logic [TIME_BITS-1:0] t_us);
        while ($urandom_range(0, 99) < send_idle) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.approve_level <= a_lvl;
        req_ch.cancel_level  <= c_lvl;
        req_ch.now_time      <= t_us;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Drop the request valid and wait until every predicted result has arrived.
    // The scoreboard count is registered, so advance once before looking at it.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Rewrite all four registers with the block idle.
    task automatic load_settings(logic [31:0] t_ms, int h, int d, int b);
        drain();
        write_reg(CFG_TIMEOUT_MS, t_ms);
        write_reg(CFG_HOLD_TIME, 32'(h));
        write_reg(CFG_CANCEL_DEBOUNCE, 32'(d));
        write_reg(CFG_RELEASE_BOUNCE, 32'(b));
        hold_set   = h;
        deb_set    = d;
        bounce_set = b;
    endtask

    // Short timeouts and thresholds, so that sessions reach every outcome.
    task automatic load_small_settings();
        load_settings($urandom_range(0, 2), $urandom_range(1, 300), $urandom_range(0, 80),
                      $urandom_range(0, 60));
    endtask

    task automatic set_idling(int s, int r);
        send_idle = s;
        recv_idle <= r;
    endtask

    // One prompt: a start and then a run of polls. Most sessions release approve first,
    // press it with short release blips and sometimes hold cancel; the rest are noise.
    task automatic run_session(int polls);
        int press_at;
        int cancel_at;
        int step_max;
        int adv;
        int i;
        bit cancel_held;
        bit tidy;
        bit a;
        bit c;
        case ($urandom_range(0, 19))
            0, 1:    now_us = TIME_BITS'({$urandom, $urandom});
            2:       now_us = TIME_MAX - TIME_BITS'($urandom_range(0, 5000));
            default: ;
        endcase
        send_request(OP_START, 1'($urandom), 1'($urandom), now_us);

        press_at    = $urandom_range(0, 3);
        cancel_held = ($urandom_range(0, 4) == 0);
        cancel_at   = $urandom_range(0, polls);
        tidy        = ($urandom_range(0, 9) != 0);

        // Scale the time step to the thresholds; some sessions run fast to hit deadlines.
        step_max = hold_set / 5 + bounce_set / 3 + deb_set / 4 + 3;
        if ($urandom_range(0, 4) == 0)
            step_max = step_max * 4;
        if (step_max > (1 << 24))
            step_max = 1 << 24;

        for (i = 0; i < polls; i++) begin
            adv = $urandom_range(0, step_max);
            if ($urandom_range(0, 29) == 0) begin
                // Step the clock backwards a little.
                if (now_us > 40)
                    now_us = now_us - TIME_BITS'($urandom_range(1, 40));
            end
            else if (now_us > TIME_MAX - TIME_BITS'(adv)) begin
                now_us = TIME_MAX;
            end
            else begin
                now_us = now_us + TIME_BITS'(adv);
            end

            if (!tidy || $urandom_range(0, 19) == 0) begin
                a = 1'($urandom);
                c = 1'($urandom);
            end
            else begin
                a = (i >= press_at) && ($urandom_range(0, 9) != 0);
                c = cancel_held ? (i >= cancel_at) : ($urandom_range(0, 29) == 0);
            end

            // Now and then restart the prompt in the middle of a session.
            if ($urandom_range(0, 24) == 0)
                send_request(OP_START, a, c, now_us);
            else
                send_request(OP_POLL, a, c, now_us);
        end
    endtask

    // Run sessions until the phase has its share of requests; pause for a full
    // drain now and then.
    task automatic run_phase(int items);
        int stop_at;
        stop_at = sent + items;
        while (sent < stop_at) begin
            if ($urandom_range(0, 19) == 0)
                drain();
            run_session($urandom_range(3, 25));
        end
    endtask

    initial begin
        // Drive every input to a known value before the first edge.
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_POLL;
        req_ch.approve_level = 1'b0;
        req_ch.cancel_level  = 1'b0;
        req_ch.now_time      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_TIMEOUT_MS;
        cfg_ch.data          = '0;
        hold_set             = int'(HOLD_RST);
        deb_set              = int'(DEBOUNCE_RST);
        bounce_set           = int'(BOUNCE_RST);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the reset settings.
        // Poll before any prompt exists: idle, nothing changes.
        send_request(OP_POLL, 1'b1, 1'b1, 48'd5);
        // Arm, poll with both buttons stale, release, then hold approve to a grant.
        send_request(OP_START, 1'b0, 1'b0, 48'd100);
        send_request(OP_POLL, 1'b1, 1'b1, 48'd200);
        send_request(OP_POLL, 1'b0, 1'b0, 48'd300);
        send_request(OP_POLL, 1'b1, 1'b0, 48'd1000);
        send_request(OP_POLL, 1'b1, 1'b0, 48'd1001000);
        send_request(OP_POLL, 1'b1, 1'b0, 48'd2001000);
        // Poll after the grant: the status holds.
        send_request(OP_POLL, 1'b0, 1'b1, 48'd2002000);

        // Zero timeout: the prompt expires on its first poll.
        load_settings(32'd0, 100, 0, 0);
        send_request(OP_START, 1'b1, 1'b1, 48'd5000);
        send_request(OP_POLL, 1'b0, 1'b0, 48'd5000);
        send_request(OP_POLL, 1'b1, 1'b0, 48'd5100);

        // Largest settings near the top of the time range: the deadline saturates,
        // and one poll steps the clock backwards.
        load_settings(32'hFFFF_FFFF, THR_MAX, THR_MAX, THR_MAX);
        send_request(OP_START, 1'b0, 1'b0, TIME_MAX - 48'd1000);
        send_request(OP_POLL, 1'b0, 1'b0, TIME_MAX - 48'd900);
        send_request(OP_POLL, 1'b1, 1'b1, TIME_MAX - 48'd800);
        send_request(OP_POLL, 1'b1, 1'b1, TIME_MAX - 48'd900);
        send_request(OP_POLL, 1'b0, 1'b0, TIME_MAX);
        send_request(OP_START, 1'b1, 1'b1, TIME_MAX);
        send_request(OP_POLL, 1'b1, 1'b0, TIME_MAX);

        // Zero hold time: approve grants at once unless cancel is down.
        load_settings(32'd1, 0, 5, 3);
        send_request(OP_START, 1'b0, 1'b0, 48'd0);
        send_request(OP_POLL, 1'b0, 1'b0, 48'd10);
        send_request(OP_POLL, 1'b1, 1'b0, 48'd10);
        send_request(OP_START, 1'b0, 1'b0, 48'd20);
        send_request(OP_POLL, 1'b0, 1'b0, 48'd20);
        send_request(OP_POLL, 1'b1, 1'b1, 48'd21);
        send_request(OP_POLL, 1'b1, 1'b1, 48'd23);
        send_request(OP_POLL, 1'b1, 1'b1, 48'd26);
        now_us = 48'd100;

        // Random part, sender idling lightly and receiver heavily.
        set_idling(25, 72);
        load_settings(32'd1, 100, 20, 15);
        run_phase(PHASE_ITEMS);
        load_small_settings();
        run_phase(PHASE_ITEMS);
        // Smallest thresholds; hold the receiver off while requests keep coming.
        load_settings(32'd0, 1, 0, 0);
        stall_asked <= stall_asked + 1;
        run_phase(PHASE_ITEMS);

        // Swap the idle rates.
        set_idling(72, 25);
        load_small_settings();
        run_phase(PHASE_ITEMS);
        load_settings(32'hFFFF_FFFF, THR_MAX, THR_MAX, THR_MAX);
        run_phase(PHASE_ITEMS);
        load_small_settings();
        run_phase(PHASE_ITEMS);

        // Full rate on both sides.
        set_idling(0, 0);
        load_small_settings();
        run_phase(PHASE_ITEMS);
        load_settings($urandom, $urandom_range(1, THR_MAX), $urandom_range(0, THR_MAX),
                      $urandom_range(0, THR_MAX));
        run_phase(PHASE_ITEMS);
        load_small_settings();
        run_phase(PHASE_ITEMS);

        // Wait out the last results, then let the block settle before the verdict.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/hap_pkg.sv
hdl/hap_if.sv
hdl/hap_ctrl.sv
hdl/hap_datapath.sv
hdl/hold_to_approve_prompt.sv
hdl/hap_checker.sv
test/hap_prompt_check.sv
test/tb_top.sv
